/* rtl/core/particle_euler_step_assert.svh */
// Assertion macros for the particle Euler step block
`ifndef PARTICLE_EULER_STEP_ASSERT_SVH
`define PARTICLE_EULER_STEP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset
`define PES_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pes assertion failed");
// Next-cycle implication, checked outside reset
`define PES_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pes assertion failed");
`else
`define PES_ASSERT_IMP(lbl, ck, rst_n, ante, cons)
`define PES_ASSERT_NXT(lbl, ck, rst_n, ante, cons)
`endif
`endif

/* rtl/core/pes_pkg.sv */
// Shared types, constants and helpers for the particle Euler step block
package pes_pkg;

	localparam int AGE_W    = 31;
	localparam int FADD_LAT = 6;
	localparam int FMUL_LAT = 5;
	localparam int LANE_LAT = 20;
	localparam int TOP_LAT  = LANE_LAT + 1;

	typedef logic [63:0] dbl_t;
	typedef logic [31:0] flt_t;

	// Special-operand outcome carried down an arithmetic pipe
	typedef struct packed {
		logic nan;
		logic inf;
		logic sgn;
	} fspec_t;

	localparam logic [10:0] EXP_MAX   = 11'h7FF;
	localparam dbl_t        CANON_NAN = 64'h7FF8_0000_0000_0000;
	localparam dbl_t        GRAV_K    = 64'h3FA4_7AE1_47AE_147B;
	localparam flt_t        DRAG_F    = 32'h3F7A_E148;

	// Count leading zeros by halving search; caller pads so input is nonzero
	function automatic logic [7:0] lzc128(input logic [127:0] v);
		logic [127:0] x;
		logic [7:0]   n;
		x = v;
		n = 8'd0;
		if (x[127:64] == 64'd0) begin
			n[6] = 1'b1;
			x = x << 64;
		end
		if (x[127:96] == 32'd0) begin
			n[5] = 1'b1;
			x = x << 32;
		end
		if (x[127:112] == 16'd0) begin
			n[4] = 1'b1;
			x = x << 16;
		end
		if (x[127:120] == 8'd0) begin
			n[3] = 1'b1;
			x = x << 8;
		end
		if (x[127:124] == 4'd0) begin
			n[2] = 1'b1;
			x = x << 4;
		end
		if (x[127:126] == 2'd0) begin
			n[1] = 1'b1;
			x = x << 2;
		end
		if (!x[127]) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

endpackage

/* rtl/core/pes_fadd.sv */
// Six-stage binary64 adder, round to nearest even, canonical NaN out
module pes_fadd (
	input  logic          clk,
	input  logic          en,
	input  pes_pkg::dbl_t a,
	input  pes_pkg::dbl_t b,
	output pes_pkg::dbl_t y
);

	// Stage 1: classify operands and order by magnitude
	logic a_nan, a_inf, b_nan, b_inf, swap;
	pes_pkg::dbl_t big_s1, sml_s1;
	pes_pkg::fspec_t sp_s1;

	assign a_nan = (a[62:52] == pes_pkg::EXP_MAX) && (a[51:0] != 52'd0);
	assign b_nan = (b[62:52] == pes_pkg::EXP_MAX) && (b[51:0] != 52'd0);
	assign a_inf = (a[62:52] == pes_pkg::EXP_MAX) && (a[51:0] == 52'd0);
	assign b_inf = (b[62:52] == pes_pkg::EXP_MAX) && (b[51:0] == 52'd0);
	assign swap  = b[62:0] > a[62:0];

	always_ff @(posedge clk) begin
		if (en) begin
			big_s1     <= swap ? b : a;
			sml_s1     <= swap ? a : b;
			sp_s1.nan  <= a_nan | b_nan | (a_inf & b_inf & (a[63] ^ b[63]));
			sp_s1.inf  <= a_inf | b_inf;
			sp_s1.sgn  <= a_inf ? a[63] : b[63];
		end
	end

	// Stage 2: align the smaller operand, keep guard, round and sticky
	logic [10:0] eb2, es2, d2;
	logic [52:0] mb2, ms2;
	logic [55:0] sh2, mask2, al2;
	logic [55:0] ma_s2, al_s2;
	logic [10:0] e_s2;
	logic sgn_s2, sub_s2;
	pes_pkg::fspec_t sp_s2;

	assign eb2 = (big_s1[62:52] == 11'd0) ? 11'd1 : big_s1[62:52];
	assign es2 = (sml_s1[62:52] == 11'd0) ? 11'd1 : sml_s1[62:52];
	assign mb2 = {big_s1[62:52] != 11'd0, big_s1[51:0]};
	assign ms2 = {sml_s1[62:52] != 11'd0, sml_s1[51:0]};
	assign d2  = eb2 - es2;
	assign sh2 = {ms2, 3'b000};

	always_comb begin
		mask2 = ~({56{1'b1}} << d2[5:0]);
		al2   = sh2 >> d2[5:0];
		if (d2 >= 11'd56) begin
			al2 = {55'd0, ms2 != 53'd0};
		end else begin
			al2[0] = al2[0] | ((sh2 & mask2) != 56'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s2  <= {mb2, 3'b000};
			al_s2  <= al2;
			e_s2   <= eb2;
			sgn_s2 <= big_s1[63];
			sub_s2 <= big_s1[63] ^ sml_s1[63];
			sp_s2  <= sp_s1;
		end
	end

	// Stage 3: add or subtract magnitudes
	logic [56:0] sum3, sum_s3;
	logic [10:0] e_s3;
	logic sgn_s3, sub_s3;
	pes_pkg::fspec_t sp_s3;

	assign sum3 = sub_s2 ? ({1'b0, ma_s2} - {1'b0, al_s2}) : ({1'b0, ma_s2} + {1'b0, al_s2});

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sum3;
			e_s3   <= e_s2;
			sgn_s3 <= sgn_s2;
			sub_s3 <= sub_s2;
			sp_s3  <= sp_s2;
		end
	end

	// Stage 4: find the normalizing shift, limited by the exponent floor
	logic [7:0]  lz4;
	logic [10:0] emax4;
	logic [5:0]  sh4, sh_s4;
	logic [56:0] sum_s4;
	logic [10:0] e_s4;
	logic cy_s4, zero_s4, sgn_s4, sub_s4;
	pes_pkg::fspec_t sp_s4;

	assign lz4   = pes_pkg::lzc128({sum_s3[55:0], {72{1'b1}}});
	assign emax4 = e_s3 - 11'd1;
	assign sh4   = ({3'b000, lz4} < emax4) ? lz4[5:0] : emax4[5:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4  <= sum_s3;
			sh_s4   <= sh4;
			e_s4    <= e_s3;
			cy_s4   <= sum_s3[56];
			zero_s4 <= (sum_s3 == 57'd0);
			sgn_s4  <= sgn_s3;
			sub_s4  <= sub_s3;
			sp_s4   <= sp_s3;
		end
	end

	// Stage 5: normalize the sum
	logic [55:0] m5, m_s5;
	logic [11:0] e5, e_s5;
	logic zero_s5, sgn_s5, sub_s5;
	pes_pkg::fspec_t sp_s5;

	always_comb begin
		if (cy_s4) begin
			m5 = {sum_s4[56:2], sum_s4[1] | sum_s4[0]};
			e5 = {1'b0, e_s4} + 12'd1;
		end else begin
			m5 = sum_s4[55:0] << sh_s4;
			e5 = {1'b0, e_s4} - {6'd0, sh_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s5    <= m5;
			e_s5    <= e5;
			zero_s5 <= zero_s4;
			sgn_s5  <= sgn_s4;
			sub_s5  <= sub_s4;
			sp_s5   <= sp_s4;
		end
	end

	// Stage 6: round to nearest even and pack
	logic [52:0] keep6;
	logic        inc6;
	logic [53:0] r6;
	logic [11:0] ex6;
	logic [51:0] fr6;
	pes_pkg::dbl_t y6, y_s6;

	assign keep6 = m_s5[55:3];
	assign inc6  = m_s5[2] & (m_s5[1] | m_s5[0] | m_s5[3]);
	assign r6    = {1'b0, keep6} + {53'd0, inc6};

	always_comb begin
		if (r6[53]) begin
			ex6 = e_s5 + 12'd1;
			fr6 = 52'd0;
		end else begin
			ex6 = r6[52] ? e_s5 : 12'd0;
			fr6 = r6[51:0];
		end
	end

	always_comb begin
		priority if (sp_s5.nan) begin
			y6 = pes_pkg::CANON_NAN;
		end else if (sp_s5.inf) begin
			y6 = {sp_s5.sgn, pes_pkg::EXP_MAX, 52'd0};
		end else if (zero_s5) begin
			y6 = {sgn_s5 & ~sub_s5, 63'd0};
		end else if (ex6 >= {1'b0, pes_pkg::EXP_MAX}) begin
			y6 = {sgn_s5, pes_pkg::EXP_MAX, 52'd0};
		end else begin
			y6 = {sgn_s5, ex6[10:0], fr6};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s6 <= y6;
		end
	end

	assign y = y_s6;

endmodule

/* rtl/core/pes_fmul.sv */
// Five-stage binary64 by binary32 multiplier, binary64 result, nearest even
module pes_fmul (
	input  logic          clk,
	input  logic          en,
	input  pes_pkg::dbl_t a,
	input  pes_pkg::flt_t b,
	output pes_pkg::dbl_t y
);

	// Stage 1: classify, unpack and form two partial products
	logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
	logic [10:0] ea1;
	logic [7:0]  eb1;
	logic [52:0] ma1;
	logic [23:0] mb1;
	logic [52:0] pph1, pph_s1;
	logic [47:0] ppl1, ppl_s1;
	logic signed [12:0] e01, e0_s1;
	logic zero_s1;
	pes_pkg::fspec_t sp_s1;

	assign a_nan  = (a[62:52] == pes_pkg::EXP_MAX) && (a[51:0] != 52'd0);
	assign a_inf  = (a[62:52] == pes_pkg::EXP_MAX) && (a[51:0] == 52'd0);
	assign a_zero = (a[62:0] == 63'd0);
	assign b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	assign b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
	assign b_zero = (b[30:0] == 31'd0);
	assign ea1    = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
	assign eb1    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
	assign ma1    = {a[62:52] != 11'd0, a[51:0]};
	assign mb1    = {b[30:23] != 8'd0, b[22:0]};
	assign pph1   = ma1[52:24] * mb1;
	assign ppl1   = ma1[23:0] * mb1;
	assign e01    = $signed({2'b00, ea1}) + $signed({5'd0, eb1}) - 13'sd126;

	always_ff @(posedge clk) begin
		if (en) begin
			pph_s1    <= pph1;
			ppl_s1    <= ppl1;
			e0_s1     <= e01;
			zero_s1   <= a_zero | b_zero;
			sp_s1.nan <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
			sp_s1.inf <= a_inf | b_inf;
			sp_s1.sgn <= a[63] ^ b[31];
		end
	end

	// Stage 2: combine partial products
	logic [76:0] p_s2;
	logic signed [12:0] e0_s2;
	logic zero_s2;
	pes_pkg::fspec_t sp_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2    <= {pph_s1, 24'd0} + {29'd0, ppl_s1};
			e0_s2   <= e0_s1;
			zero_s2 <= zero_s1;
			sp_s2   <= sp_s1;
		end
	end

	// Stage 3: choose left normalize or right denormalize amount
	logic [7:0]  lz3;
	logic signed [12:0] en3, rr3;
	logic        rsh3, rsh_s3;
	logic [6:0]  amt3, amt_s3;
	logic [12:0] er3, er_s3;
	logic [76:0] p_s3;
	logic zero_s3;
	pes_pkg::fspec_t sp_s3;

	assign lz3 = pes_pkg::lzc128({p_s2, {51{1'b1}}});
	assign en3 = e0_s2 - $signed({5'd0, lz3});
	assign rr3 = 13'sd1 - e0_s2;

	always_comb begin
		if (e0_s2 < 13'sd1) begin
			rsh3 = 1'b1;
			amt3 = rr3[6:0];
			er3  = 13'd1;
		end else if (en3 >= 13'sd1) begin
			rsh3 = 1'b0;
			amt3 = lz3[6:0];
			er3  = en3;
		end else begin
			rsh3 = 1'b0;
			amt3 = rr3[6:0] + 7'd0 - rr3[6:0] + 7'(e0_s2 - 13'sd1);
			er3  = 13'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3    <= p_s2;
			rsh_s3  <= rsh3;
			amt_s3  <= amt3;
			er_s3   <= er3;
			zero_s3 <= zero_s2;
			sp_s3   <= sp_s2;
		end
	end

	// Stage 4: shift the product into place, fold lost bits into sticky
	logic [76:0] mask4, x4, x_s4;
	logic [12:0] er_s4;
	logic zero_s4;
	pes_pkg::fspec_t sp_s4;

	always_comb begin
		mask4 = ~({77{1'b1}} << amt_s3);
		if (!rsh_s3) begin
			x4 = p_s3 << amt_s3;
		end else if (amt_s3 >= 7'd77) begin
			x4 = {76'd0, p_s3 != 77'd0};
		end else begin
			x4    = p_s3 >> amt_s3;
			x4[0] = x4[0] | ((p_s3 & mask4) != 77'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4    <= x4;
			er_s4   <= er_s3;
			zero_s4 <= zero_s3;
			sp_s4   <= sp_s3;
		end
	end

	// Stage 5: round to nearest even and pack
	logic [52:0] keep5;
	logic        inc5;
	logic [53:0] r5;
	logic [12:0] ex5;
	logic [51:0] fr5;
	pes_pkg::dbl_t y5, y_s5;

	assign keep5 = x_s4[76:24];
	assign inc5  = x_s4[23] & ((x_s4[22:0] != 23'd0) | x_s4[24]);
	assign r5    = {1'b0, keep5} + {53'd0, inc5};

	always_comb begin
		if (r5[53]) begin
			ex5 = er_s4 + 13'd1;
			fr5 = 52'd0;
		end else begin
			ex5 = r5[52] ? er_s4 : 13'd0;
			fr5 = r5[51:0];
		end
	end

	always_comb begin
		priority if (sp_s4.nan) begin
			y5 = pes_pkg::CANON_NAN;
		end else if (sp_s4.inf) begin
			y5 = {sp_s4.sgn, pes_pkg::EXP_MAX, 52'd0};
		end else if (zero_s4) begin
			y5 = {sp_s4.sgn, 63'd0};
		end else if (ex5 >= {2'b00, pes_pkg::EXP_MAX}) begin
			y5 = {sp_s4.sgn, pes_pkg::EXP_MAX, 52'd0};
		end else begin
			y5 = {sp_s4.sgn, ex5[10:0], fr5};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s5 <= y5;
		end
	end

	assign y = y_s5;

endmodule

/* rtl/core/pes_axis.sv */
// Horizontal lane: box-center position update and drag for one axis
module pes_axis (
	input  logic          clk,
	input  logic          en,
	input  pes_pkg::dbl_t pos,
	input  pes_pkg::dbl_t vel,
	input  pes_pkg::flt_t wid,
	output pes_pkg::dbl_t npos,
	output pes_pkg::dbl_t nvel
);

	localparam int VD = 1 + pes_pkg::FADD_LAT;
	localparam int DD = pes_pkg::LANE_LAT - pes_pkg::FMUL_LAT;

	// Halve a binary32 width with nearest even, then widen to binary64
	function automatic pes_pkg::dbl_t half_dbl(input pes_pkg::flt_t w);
		logic [23:0] m, r;
		logic [7:0]  he, lz;
		logic [22:0] hf, nf;
		logic [10:0] de;
		pes_pkg::dbl_t d;
		m  = {w[23], w[22:0]};
		r  = {1'b0, m[23:1]} + {23'd0, m[0] & m[1]};
		he = w[30:23];
		hf = w[22:0];
		if ((w[30:23] != 8'hFF) && (w[30:23] >= 8'd2)) begin
			he = w[30:23] - 8'd1;
		end else if (w[30:23] != 8'hFF) begin
			he = {7'd0, r[23]};
			hf = r[22:0];
		end
		lz = pes_pkg::lzc128({hf, {105{1'b1}}});
		nf = hf << (lz[4:0] + 5'd1);
		de = 11'd896 - {3'd0, lz};
		if (he == 8'hFF) begin
			d = {w[31], pes_pkg::EXP_MAX, hf, 29'd0};
		end else if (he != 8'd0) begin
			d = {w[31], {3'd0, he} + 11'd896, hf, 29'd0};
		end else if (hf == 23'd0) begin
			d = {w[31], 63'd0};
		end else begin
			d = {w[31], de, nf, 29'd0};
		end
		return d;
	endfunction

	// Halve a binary64 value exactly or with nearest even in the subnormal range
	function automatic pes_pkg::dbl_t halve(input pes_pkg::dbl_t x);
		logic [52:0] r;
		pes_pkg::dbl_t h;
		r = {1'b0, x[52:1]} + {52'd0, x[0] & x[1]};
		if (x[62:52] == pes_pkg::EXP_MAX) begin
			h = x;
		end else if (x[62:52] >= 11'd2) begin
			h = {x[63], x[62:52] - 11'd1, x[51:0]};
		end else begin
			h = {x[63], 10'd0, r[52], r[51:0]};
		end
		return h;
	endfunction

	// Register half width and position
	pes_pkg::dbl_t h_s1, p_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1 <= half_dbl(wid);
			p_s1 <= pos;
		end
	end

	// Form both box bounds
	pes_pkg::dbl_t lo_a, hi_a, lo_b, hi_b, sum_c;

	pes_fadd u_lo_a (.clk(clk), .en(en), .a(p_s1), .b({~h_s1[63], h_s1[62:0]}), .y(lo_a));
	pes_fadd u_hi_a (.clk(clk), .en(en), .a(p_s1), .b(h_s1), .y(hi_a));

	// Delay motion to meet the bounds
	pes_pkg::dbl_t vel_q [VD];

	always_ff @(posedge clk) begin
		if (en) begin
			vel_q[0] <= vel;
			for (int i = 1; i < VD; i++) begin
				vel_q[i] <= vel_q[i-1];
			end
		end
	end

	// Move both bounds, then sum them
	pes_fadd u_lo_b (.clk(clk), .en(en), .a(lo_a), .b(vel_q[VD-1]), .y(lo_b));
	pes_fadd u_hi_b (.clk(clk), .en(en), .a(hi_a), .b(vel_q[VD-1]), .y(hi_b));
	pes_fadd u_sum  (.clk(clk), .en(en), .a(lo_b), .b(hi_b), .y(sum_c));

	// Take the mean of the bounds
	pes_pkg::dbl_t npos_s20;

	always_ff @(posedge clk) begin
		if (en) begin
			npos_s20 <= halve(sum_c);
		end
	end

	assign npos = npos_s20;

	// Apply drag and hold until the position is ready
	pes_pkg::dbl_t vdrag;
	pes_pkg::dbl_t drag_q [DD];

	pes_fmul u_drag (.clk(clk), .en(en), .a(vel), .b(pes_pkg::DRAG_F), .y(vdrag));

	always_ff @(posedge clk) begin
		if (en) begin
			drag_q[0] <= vdrag;
			for (int i = 1; i < DD; i++) begin
				drag_q[i] <= drag_q[i-1];
			end
		end
	end

	assign nvel = drag_q[DD-1];

endmodule

/* rtl/core/pes_vert.sv */
// Vertical lane: gravity, position update and drag
module pes_vert (
	input  logic          clk,
	input  logic          en,
	input  pes_pkg::dbl_t pos,
	input  pes_pkg::dbl_t vel,
	input  pes_pkg::flt_t grav,
	output pes_pkg::dbl_t npos,
	output pes_pkg::dbl_t nvel
);

	localparam int VD = pes_pkg::FMUL_LAT;
	localparam int PD = pes_pkg::FMUL_LAT + pes_pkg::FADD_LAT;
	localparam int ND = pes_pkg::LANE_LAT - PD - pes_pkg::FADD_LAT;
	localparam int DD = pes_pkg::LANE_LAT - PD - pes_pkg::FMUL_LAT;

	// Scale gravity by the tick constant
	pes_pkg::dbl_t gk;

	pes_fmul u_grav (.clk(clk), .en(en), .a(pes_pkg::GRAV_K), .b(grav), .y(gk));

	// Delay motion and position to meet their operands
	pes_pkg::dbl_t vel_q [VD];
	pes_pkg::dbl_t pos_q [PD];

	always_ff @(posedge clk) begin
		if (en) begin
			vel_q[0] <= vel;
			pos_q[0] <= pos;
			for (int i = 1; i < VD; i++) begin
				vel_q[i] <= vel_q[i-1];
			end
			for (int i = 1; i < PD; i++) begin
				pos_q[i] <= pos_q[i-1];
			end
		end
	end

	// Take gravity off the motion
	pes_pkg::dbl_t vnew;

	pes_fadd u_vsub (.clk(clk), .en(en), .a(vel_q[VD-1]), .b({~gk[63], gk[62:0]}), .y(vnew));

	// Advance position and apply drag
	pes_pkg::dbl_t pnew, vdrag;

	pes_fadd u_padd (.clk(clk), .en(en), .a(pos_q[PD-1]), .b(vnew), .y(pnew));
	pes_fmul u_drag (.clk(clk), .en(en), .a(vnew), .b(pes_pkg::DRAG_F), .y(vdrag));

	// Align both results to the lane latency
	pes_pkg::dbl_t np_q [ND];
	pes_pkg::dbl_t nv_q [DD];

	always_ff @(posedge clk) begin
		if (en) begin
			np_q[0] <= pnew;
			nv_q[0] <= vdrag;
			for (int i = 1; i < ND; i++) begin
				np_q[i] <= np_q[i-1];
			end
			for (int i = 1; i < DD; i++) begin
				nv_q[i] <= nv_q[i-1];
			end
		end
	end

	assign npos = np_q[ND-1];
	assign nvel = nv_q[DD-1];

endmodule

/* rtl/core/particle_euler_step.sv */
// Top level: particle Euler step, three axis lanes and the output merge
//
// One particle enters per transfer on the item channel (item_valid and
// item_stall) carrying binary64 position and motion, binary32 gravity and
// width, and its age. The updated particle leaves on the result channel
// (result_valid and result_stall), one result for every item, in order.
// The latency from the item transfer to result_valid is set by the x and z
// lanes, which run a width halving stage, three chained six-stage binary64
// adders and a final halving stage, plus the merge register. Throughput is
// one particle every cycle while the receiver does not stall a result.
// While the receiver stalls a waiting result, the whole pipeline holds and
// item_stall is raised in the same cycle; bubbles do not collapse.
// Reset clears the valid pipeline, so no result is shown until an item has
// passed through; the arithmetic registers carry no reset.
module particle_euler_step (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [63:0]                pos_x_bits,
	input  logic [63:0]                pos_y_bits,
	input  logic [63:0]                pos_z_bits,
	input  logic [63:0]                vel_x_bits,
	input  logic [63:0]                vel_y_bits,
	input  logic [63:0]                vel_z_bits,
	input  logic [pes_pkg::AGE_W-1:0]  age_in,
	input  logic [31:0]                gravity_bits,
	input  logic [31:0]                width_bits,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [63:0]                new_pos_x_bits,
	output logic [63:0]                new_pos_y_bits,
	output logic [63:0]                new_pos_z_bits,
	output logic [63:0]                new_vel_x_bits,
	output logic [63:0]                new_vel_y_bits,
	output logic [63:0]                new_vel_z_bits,
	output logic [pes_pkg::AGE_W-1:0]  age_out
);

	`include "particle_euler_step_assert.svh"

	localparam int LAT = pes_pkg::TOP_LAT;

	// Advance the pipeline unless a finished result is held
	logic en;
	logic [LAT-1:0] vld_q;

	assign en         = !(vld_q[LAT-1] && result_stall);
	assign item_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], item_valid};
		end
	end

	// Run the three lanes side by side
	pes_pkg::dbl_t px, pz, vx, vz, py, vy;

	pes_axis u_x (
		.clk(clk), .en(en), .pos(pos_x_bits), .vel(vel_x_bits), .wid(width_bits),
		.npos(px), .nvel(vx)
	);

	pes_axis u_z (
		.clk(clk), .en(en), .pos(pos_z_bits), .vel(vel_z_bits), .wid(width_bits),
		.npos(pz), .nvel(vz)
	);

	pes_vert u_y (
		.clk(clk), .en(en), .pos(pos_y_bits), .vel(vel_y_bits), .grav(gravity_bits),
		.npos(py), .nvel(vy)
	);

	// Step the age with saturation and carry it alongside
	logic [pes_pkg::AGE_W-1:0] age_inc;
	logic [pes_pkg::AGE_W-1:0] age_q [LAT];

	assign age_inc = (age_in == '1) ? age_in : age_in + 1'b1;

	always_ff @(posedge clk) begin
		if (en) begin
			age_q[0] <= age_inc;
			for (int i = 1; i < LAT; i++) begin
				age_q[i] <= age_q[i-1];
			end
		end
	end

	// Merge lane results into the output register
	pes_pkg::dbl_t npx_q, npy_q, npz_q, nvx_q, nvy_q, nvz_q;

	always_ff @(posedge clk) begin
		if (en) begin
			npx_q <= px;
			npy_q <= py;
			npz_q <= pz;
			nvx_q <= vx;
			nvy_q <= vy;
			nvz_q <= vz;
		end
	end

	assign result_valid   = vld_q[LAT-1];
	assign new_pos_x_bits = npx_q;
	assign new_pos_y_bits = npy_q;
	assign new_pos_z_bits = npz_q;
	assign new_vel_x_bits = nvx_q;
	assign new_vel_y_bits = nvy_q;
	assign new_vel_z_bits = nvz_q;
	assign age_out        = age_q[LAT-1];

	// Check pipeline control and result encoding
	`PES_ASSERT_NXT(a_xfer_enters, clk, arst_n, item_valid && !item_stall, vld_q[0])
	`PES_ASSERT_NXT(a_hold_freezes, clk, arst_n, !en, $stable(vld_q))
	`PES_ASSERT_IMP(a_age_nonzero, clk, arst_n, result_valid, age_out != '0)
	`PES_ASSERT_IMP(a_nan_canon, clk, arst_n, result_valid && new_vel_y_bits[62:52] == pes_pkg::EXP_MAX && new_vel_y_bits[51:0] != 52'd0, new_vel_y_bits == pes_pkg::CANON_NAN)

endmodule
